// ===== rtl/core/prime_count_stream_macros.svh =====
// assertion macros for the prime count stream block
`ifndef PRIME_COUNT_STREAM_MACROS_SVH
`define PRIME_COUNT_STREAM_MACROS_SVH

// checked only while out of reset
`define PCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define PCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/pcs_pkg.sv =====
// shared constants and control types for the prime count stream block
package pcs_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FIELD_W         = 32;
  localparam int COUNT_W         = 32;
  localparam int FIRST_PRIME     = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // tester control from the top level
  typedef struct packed {
    logic start;
    logic take;
  } tst_ctrl_t;

  // tester status to the top level
  typedef struct packed {
    logic idle;
    logic done;
    logic is_prime;
  } tst_stat_t;

  // remainder unit control and status
  typedef struct packed {
    logic start;
  } rem_ctrl_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } rem_stat_t;

endpackage

// ===== rtl/core/pcs_if.sv =====
// valid/ready channel interfaces for the input and result streams
interface pcs_in_if;
  logic                          valid;
  logic                          ready;
  logic [pcs_pkg::FIELD_W-1:0]   value;
  logic                          last;

  modport source (output valid, value, last, input ready);
  modport sink (input valid, value, last, output ready);
endinterface

interface pcs_out_if;
  logic                          valid;
  logic                          ready;
  logic                          is_prime;
  logic [pcs_pkg::COUNT_W-1:0]   prime_count;
  logic                          end_of_list;

  modport source (output valid, is_prime, prime_count, end_of_list, input ready);
  modport sink (input valid, is_prime, prime_count, end_of_list, output ready);
endinterface

// ===== rtl/core/pcs_rem_serial.sv =====
// bit-serial restoring remainder unit, one dividend bit per cycle
module pcs_rem_serial #(
  parameter int TEST_W = pcs_pkg::VALUE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pcs_pkg::rem_ctrl_t  ctrl,
  input  logic [TEST_W-1:0]   dividend,
  input  logic [TEST_W-1:0]   divisor,
  output pcs_pkg::rem_stat_t  stat
);

  localparam int CNT_W = $clog2(TEST_W);

  logic [TEST_W-1:0] sh_r, sh_nxt;
  logic [TEST_W-1:0] rem_r, rem_nxt;
  logic [TEST_W-1:0] div_r, div_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [TEST_W:0]   trial;
  logic [TEST_W:0]   diff;

  assign trial = {rem_r, sh_r[TEST_W-1]};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctrl.start) begin
      sh_nxt   = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      sh_nxt  = {sh_r[TEST_W-2:0], 1'b0};
      // keep the trial value when the subtract borrows
      rem_nxt = diff[TEST_W] ? trial[TEST_W-1:0] : diff[TEST_W-1:0];
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(TEST_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign stat.done     = done_r;
  assign stat.rem_zero = (rem_r == '0);

endmodule

// ===== rtl/core/pcs_trial_seq.sv =====
// trial divisor sequencer: odd divisors from 3 while the square stays in range
module pcs_trial_seq #(
  parameter int TEST_W = pcs_pkg::VALUE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pcs_pkg::tst_ctrl_t  ctrl,
  input  logic [TEST_W-1:0]   value,
  output pcs_pkg::tst_stat_t  stat
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]        st_r, st_nxt;
  logic [TEST_W-1:0] n_r, n_nxt;
  logic [TEST_W-1:0] d_r, d_nxt;
  logic [TEST_W:0]   sq_r, sq_nxt;
  logic [TEST_W:0]   q_r, q_nxt;
  logic              prime_r, prime_nxt;

  pcs_pkg::rem_ctrl_t rem_ctrl;
  pcs_pkg::rem_stat_t rem_stat;

  pcs_rem_serial #(
    .TEST_W (TEST_W)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (rem_ctrl),
    .dividend (n_r),
    .divisor  (d_r),
    .stat     (rem_stat)
  );

  always_comb begin
    st_nxt         = st_r;
    n_nxt          = n_r;
    d_nxt          = d_r;
    sq_nxt         = sq_r;
    q_nxt          = q_r;
    prime_nxt      = prime_r;
    rem_ctrl.start = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (ctrl.start) begin
          n_nxt = value;
          d_nxt = TEST_W'(3);
          sq_nxt = (TEST_W + 1)'(9);
          q_nxt  = (TEST_W + 1)'(16);
          if (value < TEST_W'(pcs_pkg::FIRST_PRIME)) begin
            prime_nxt = 1'b0;
            st_nxt    = ST_DONE;
          end else if (value == TEST_W'(pcs_pkg::FIRST_PRIME)) begin
            prime_nxt = 1'b1;
            st_nxt    = ST_DONE;
          end else if (!value[0]) begin
            prime_nxt = 1'b0;
            st_nxt    = ST_DONE;
          end else begin
            st_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sq_r > {1'b0, n_r}) begin
          prime_nxt = 1'b1;
          st_nxt    = ST_DONE;
        end else begin
          rem_ctrl.start = 1'b1;
          st_nxt         = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_stat.done) begin
          if (rem_stat.rem_zero) begin
            prime_nxt = 1'b0;
            st_nxt    = ST_DONE;
          end else begin
            // (d+2)^2 = d^2 + (4d+4), step of that term is 8
            d_nxt  = d_r + TEST_W'(2);
            sq_nxt = sq_r + q_r;
            q_nxt  = q_r + (TEST_W + 1)'(8);
            st_nxt = ST_CHECK;
          end
        end
      end
      ST_DONE: begin
        if (ctrl.take) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    n_r     <= n_nxt;
    d_r     <= d_nxt;
    sq_r    <= sq_nxt;
    q_r     <= q_nxt;
    prime_r <= prime_nxt;
  end

  assign stat.idle     = (st_r == ST_IDLE);
  assign stat.done     = (st_r == ST_DONE);
  assign stat.is_prime = prime_r;

endmodule

// ===== rtl/core/prime_count_stream.sv =====
// top level of the prime count stream block: handshakes, running count, result register
// Each accepted number is tested for primality by trial division and gives one
// result: the prime flag, the number of primes in the current list so far (this
// item included, saturating at all ones) and a copy of the last flag; the count
// returns to zero after the last item of a list. Only the low min(VALUE_WIDTH, 32)
// bits of the value are tested. The block works on one number at a time. Values
// below 3 and even values go from the idle state straight to the done state and
// reach the result register once it is free or draining. An odd value n is tried
// against odd divisors (3, 5, 7, ... up to the first divisor or up to the
// integer square root of n); each divisor takes a check state, a pass through the
// bit-serial remainder unit over all tested bits, one dividend bit per cycle,
// and a state that picks up its result. A 32-bit prime near the top of the range
// takes about 32767 divisors. A new number is taken as soon as the tester is free,
// even while the previous result still waits in the output register.
`include "prime_count_stream_macros.svh"

module prime_count_stream #(
  parameter int VALUE_WIDTH = pcs_pkg::VALUE_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  pcs_in_if.sink    in_ch,
  pcs_out_if.source out_ch
);

  // tested width: the field itself is 32 bits
  localparam int TEST_W = (VALUE_WIDTH < pcs_pkg::FIELD_W) ? VALUE_WIDTH : pcs_pkg::FIELD_W;

  pcs_pkg::tst_ctrl_t tst_ctrl;
  pcs_pkg::tst_stat_t tst_stat;

  logic                        in_xfer;
  logic                        take;
  logic [pcs_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [pcs_pkg::COUNT_W-1:0] count_new;
  logic                        last_r, last_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_prime_r, out_prime_nxt;
  logic [pcs_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;
  logic                        out_last_r, out_last_nxt;

  // input side: ready whenever the tester is free
  assign in_ch.ready = tst_stat.idle;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // a finished test moves into the result register once it is free or draining
  assign take = tst_stat.done && (!out_valid_r || out_ch.ready);

  assign tst_ctrl.start = in_xfer;
  assign tst_ctrl.take  = take;

  pcs_trial_seq #(
    .TEST_W (TEST_W)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (tst_ctrl),
    .value (in_ch.value[TEST_W-1:0]),
    .stat  (tst_stat)
  );

  // saturating count including the item being finished
  assign count_new = (tst_stat.is_prime && (count_r != pcs_pkg::COUNT_MAX))
                     ? count_r + pcs_pkg::COUNT_W'(1) : count_r;

  always_comb begin
    count_nxt     = count_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_prime_nxt = out_prime_r;
    out_count_nxt = out_count_r;
    out_last_nxt  = out_last_r;
    if (in_xfer) begin
      last_nxt = in_ch.last;
    end
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (take) begin
      out_valid_nxt = 1'b1;
      out_prime_nxt = tst_stat.is_prime;
      out_count_nxt = count_new;
      out_last_nxt  = last_r;
      // end of list clears the count for the next list
      count_nxt     = last_r ? '0 : count_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    last_r      <= last_nxt;
    out_prime_r <= out_prime_nxt;
    out_count_r <= out_count_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.is_prime    = out_prime_r;
  assign out_ch.prime_count = out_count_r;
  assign out_ch.end_of_list = out_last_r;

  // checks on the block's own bookkeeping
  `PCS_ASSERT(a_start_busy, in_xfer |=> !tst_stat.idle, "tester did not leave idle after a transfer")
  `PCS_ASSERT(a_last_clears, (take && last_r) |=> (count_r == '0), "count not cleared after end of list")
  `PCS_ASSERT(a_count_rises, (take && !last_r) |=> (count_r >= $past(count_r)), "running count fell within a list")
  `PCS_ASSERT(a_prime_counted, (out_ch.valid && out_ch.is_prime) |-> (out_ch.prime_count != '0), "prime result with zero count")
  `PCS_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_ch.valid, "result valid straight after reset")

endmodule
